>>> rtl/core/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants for the register machine execute block: opcodes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rme_pkg;

    // Memory address width; the memory aliases when this is below 16.
    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int RF_DEPTH      = 16;

    localparam logic [3:0] NIB_MASK  = 4'hF;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // Instruction opcodes.
    localparam logic [3:0] OP_HALT = 4'd0;
    localparam logic [3:0] OP_LDC  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_CP   = 4'd4;
    localparam logic [3:0] OP_ADD  = 4'd5;
    localparam logic [3:0] OP_SUB  = 4'd6;
    localparam logic [3:0] OP_MUL  = 4'd7;
    localparam logic [3:0] OP_DIV  = 4'd8;
    localparam logic [3:0] OP_NAND = 4'd9;
    localparam logic [3:0] OP_SHL  = 4'd10;
    localparam logic [3:0] OP_SHR  = 4'd11;
    localparam logic [3:0] OP_IN   = 4'd12;
    localparam logic [3:0] OP_OUT  = 4'd13;
    localparam logic [3:0] OP_READ = 4'd14;
    localparam logic [3:0] OP_WRITE = 4'd15;

    // Item commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_F1, S_RX, S_LDC, S_F2, S_RY, S_EX,
        S_STZ, S_ST0, S_ST1, S_LD0, S_LD1, S_LD2, S_DIV, S_WB, S_RESP
    } state_t;

    typedef enum logic [2:0] {
        MO_NONE, MO_RD_PC, MO_RD_B, MO_RD_B1, MO_WR_LOAD, MO_WR_LO, MO_WR_HI
    } mem_op_t;

    typedef enum logic [1:0] {
        RA_XMEM, RA_YMEM, RA_Z
    } rf_raddr_t;

    typedef enum logic [1:0] {
        WI_XMEM, WI_X, WI_Y, WI_Z
    } rf_widx_t;

    typedef enum logic [2:0] {
        WD_IN, WD_LDC, WD_LD, WD_LDY, WD_STY, WD_RES
    } rf_wdata_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      lat_in;
        mem_op_t   mem_op;
        logic      pc_inc;
        logic      rf_rd;
        rf_raddr_t rf_raddr;
        logic      rf_wr;
        rf_widx_t  rf_widx;
        rf_wdata_t rf_wdata;
        logic      lat_ir;
        logic      lat_a;
        logic      lat_j;
        logic      lat_b;
        logic      lat_c;
        logic      lat_lo;
        logic      lat_word;
        logic      alu_go;
        logic      div_go;
        logic      lat_div;
        logic      clr_out;
        logic      set_halt;
        logic      set_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       cmd;
        logic       halted;
        logic [3:0] fetch_op;
        logic [3:0] ir_op;
        logic       a_zero;
        logic       div_done;
    } dp_status_t;

endpackage

>>> rtl/core/rme_ram.sv
// ----------------------------------------------------------------------------
// rme_ram
// Generic single-port RAM with one write or read per cycle and a registered
// read.
// ----------------------------------------------------------------------------
module rme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write or read the addressed entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

>>> rtl/core/rme_div.sv
// ----------------------------------------------------------------------------
// rme_div
// Signed 16-bit divider, truncating toward zero, one quotient bit per cycle
// by restoring division on the magnitudes.
// ----------------------------------------------------------------------------
module rme_div
    import rme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [16:0] rem_sh;
    logic [16:0] rem_sub;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // One restoring step per cycle.
    always_comb
    begin
        rem_sh    = {rem_reg[15:0], q_reg[15]};
        rem_sub   = rem_sh - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = dividend[15] ? 16'(-dividend) : dividend;
            d_next    = divisor[15] ? 16'(-divisor) : divisor;
            neg_next  = dividend[15] ^ divisor[15];
        end
        else if (busy_reg)
        begin
            if (!rem_sub[16])
            begin
                rem_next = rem_sub;
                q_next   = {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 16'(-q_reg) : q_reg;

endmodule

>>> rtl/core/rme_datapath.sv
// ----------------------------------------------------------------------------
// rme_datapath
// Program counter, register file, byte memory, operand registers, ALU,
// divider and result registers, all driven by controller commands.
// ----------------------------------------------------------------------------
module rme_datapath
    import rme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd_in,
    input  logic        cmd,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output dp_status_t  status,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        halted,
    output logic [15:0] exit_value,
    output logic [15:0] program_counter
);

    localparam int AW = MEM_ADDR_BITS;

    logic        cmd_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  ir_reg;
    logic [7:0]  jb_reg;
    logic [15:0] a_reg, b_reg, c_reg, word_reg, res_reg;
    logic [7:0]  lo_reg;
    logic [15:0] pc_reg, pc_next;
    logic        halt_reg;
    logic [15:0] exit_reg;
    logic        outv_reg;
    logic [7:0]  outb_reg;
    logic [RF_DEPTH-1:0] rf_valid_reg;
    logic [3:0]  rd_idx_reg;

    logic [15:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata, mem_rdata;
    logic [3:0]  rf_ridx, rf_widx, rf_addr;
    logic [15:0] rf_wval, rf_q, rf_val;
    logic        rf_ram_we;
    logic [15:0] alu_res;
    logic [31:0] mul_full;
    logic        div_done;
    logic [15:0] div_q;
    logic [15:0] ld_yv, ld_xv;

    // Control state: program counter, halt flag, exit code, output valid flag, valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            exit_reg     <= '0;
            outv_reg     <= 1'b0;
            rf_valid_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cmd_in.set_halt)
            begin
                halt_reg <= 1'b1;
                exit_reg <= rf_val;
            end
            if (cmd_in.clr_out)
            begin
                outv_reg <= 1'b0;
            end
            else if (cmd_in.set_out)
            begin
                outv_reg <= 1'b1;
            end
            if (rf_ram_we)
            begin
                rf_valid_reg[rf_widx] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_in.lat_in)
        begin
            cmd_reg  <= cmd;
            addr_reg <= address;
            data_reg <= data;
        end
        if (cmd_in.clr_out)
        begin
            outb_reg <= '0;
        end
        else if (cmd_in.set_out)
        begin
            outb_reg <= rf_val[7:0] & BYTE_MASK;
        end
        if (cmd_in.lat_ir)
        begin
            ir_reg <= mem_rdata;
        end
        if (cmd_in.lat_a)
        begin
            a_reg <= rf_val;
        end
        if (cmd_in.lat_j)
        begin
            jb_reg <= mem_rdata;
        end
        if (cmd_in.lat_b)
        begin
            b_reg <= rf_val;
        end
        if (cmd_in.lat_c)
        begin
            c_reg <= rf_val;
        end
        if (cmd_in.lat_lo)
        begin
            lo_reg <= mem_rdata;
        end
        if (cmd_in.lat_word)
        begin
            word_reg <= {mem_rdata, lo_reg};
        end
        if (cmd_in.alu_go)
        begin
            res_reg <= alu_res;
        end
        else if (cmd_in.lat_div)
        begin
            res_reg <= (a_reg == 16'd0) ? 16'd0 : div_q;
        end
        if (cmd_in.rf_rd)
        begin
            rd_idx_reg <= rf_ridx;
        end
    end

    // Memory port: address, write enable and write data.
    always_comb
    begin
        mem_addr  = pc_reg;
        mem_we    = 1'b0;
        mem_wdata = data_reg;
        unique case (cmd_in.mem_op)
            MO_NONE:    mem_addr = pc_reg;
            MO_RD_PC:   mem_addr = pc_reg;
            MO_RD_B:    mem_addr = b_reg;
            MO_RD_B1:   mem_addr = b_reg + 16'd1;
            MO_WR_LOAD:
            begin
                mem_addr  = addr_reg;
                mem_we    = 1'b1;
                mem_wdata = data_reg;
            end
            MO_WR_LO:
            begin
                mem_addr  = b_reg;
                mem_we    = 1'b1;
                mem_wdata = c_reg[7:0];
            end
            MO_WR_HI:
            begin
                mem_addr  = b_reg + 16'd1;
                mem_we    = 1'b1;
                mem_wdata = c_reg[15:8];
            end
            default:    mem_addr = pc_reg;
        endcase
    end

    rme_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr[AW-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Register file read index.
    always_comb
    begin
        unique case (cmd_in.rf_raddr)
            RA_XMEM: rf_ridx = mem_rdata[3:0] & NIB_MASK;
            RA_YMEM: rf_ridx = mem_rdata[7:4];
            RA_Z:    rf_ridx = jb_reg[3:0];
            default: rf_ridx = mem_rdata[3:0];
        endcase
    end

    // Load post-increment sees the loaded word where indices coincide.
    assign ld_yv = (jb_reg[7:4] == jb_reg[3:0]) ? word_reg : b_reg;
    assign ld_xv = (ir_reg[3:0] == jb_reg[3:0]) ? word_reg : a_reg;

    // Register file write index and data.
    always_comb
    begin
        unique case (cmd_in.rf_widx)
            WI_XMEM: rf_widx = mem_rdata[3:0];
            WI_X:    rf_widx = ir_reg[3:0];
            WI_Y:    rf_widx = jb_reg[7:4];
            WI_Z:    rf_widx = jb_reg[3:0];
            default: rf_widx = ir_reg[3:0];
        endcase
        unique case (cmd_in.rf_wdata)
            WD_IN:   rf_wval = {8'd0, data_reg};
            WD_LDC:  rf_wval = {{8{mem_rdata[7]}}, mem_rdata};
            WD_LD:   rf_wval = {mem_rdata, lo_reg};
            WD_LDY:  rf_wval = ld_yv + ld_xv;
            WD_STY:  rf_wval = b_reg + a_reg;
            WD_RES:  rf_wval = res_reg;
            default: rf_wval = res_reg;
        endcase
    end

    // Register zero is the program counter and lives outside the RAM.
    assign rf_ram_we = cmd_in.rf_wr && (rf_widx != 4'd0);
    assign rf_addr   = cmd_in.rf_wr ? rf_widx : rf_ridx;

    always_comb
    begin
        pc_next = pc_reg;
        if (cmd_in.rf_wr && (rf_widx == 4'd0))
        begin
            pc_next = rf_wval;
        end
        else if (cmd_in.pc_inc)
        begin
            pc_next = pc_reg + 16'd1;
        end
    end

    rme_ram #(
        .WIDTH (16),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk   (clk),
        .we    (rf_ram_we),
        .addr  (rf_addr),
        .wdata (rf_wval),
        .rdata (rf_q)
    );

    // An entry never written reads as zero; register zero reads the program counter.
    assign rf_val = (rd_idx_reg == 4'd0) ? pc_reg :
                    (rf_valid_reg[rd_idx_reg] ? rf_q : 16'd0);

    // Single-cycle ALU; its result is registered before write-back.
    assign mul_full = b_reg * a_reg;

    always_comb
    begin
        unique case (ir_reg[7:4])
            OP_ADD:  alu_res = b_reg + a_reg;
            OP_SUB:  alu_res = b_reg - a_reg;
            OP_MUL:  alu_res = mul_full[15:0];
            OP_NAND: alu_res = ~(b_reg & a_reg);
            OP_SHL:  alu_res = (a_reg >= 16'd16) ? 16'd0 : (b_reg << a_reg[3:0]);
            OP_SHR:  alu_res = (a_reg >= 16'd16) ? 16'd0 : (b_reg >> a_reg[3:0]);
            default: alu_res = b_reg;
        endcase
    end

    rme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd_in.div_go),
        .dividend (b_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Status back to the controller.
    assign status.cmd      = cmd_reg;
    assign status.halted   = halt_reg;
    assign status.fetch_op = mem_rdata[7:4];
    assign status.ir_op    = ir_reg[7:4];
    assign status.a_zero   = (a_reg == 16'd0);
    assign status.div_done = div_done;

    assign out_valid       = outv_reg;
    assign out_byte        = outb_reg;
    assign halted          = halt_reg;
    assign exit_value      = exit_reg;
    assign program_counter = pc_reg;

endmodule

>>> rtl/core/rme_ctrl.sv
// ----------------------------------------------------------------------------
// rme_ctrl
// Controller state machine: accepts an item, sequences fetch, operand reads,
// execution and write-back, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rme_ctrl
    import rme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd_out
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.cmd == CMD_LOAD || status.halted)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_F1;
                end
            end
            S_F1:
            begin
                priority if (status.fetch_op == OP_HALT || status.fetch_op == OP_OUT)
                begin
                    state_next = S_RX;
                end
                else if (status.fetch_op == OP_LDC)
                begin
                    state_next = S_LDC;
                end
                else if (status.fetch_op == OP_IN)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_F2;
                end
            end
            S_RX:  state_next = S_RESP;
            S_LDC: state_next = S_RESP;
            S_F2:  state_next = S_RY;
            S_RY:  state_next = S_EX;
            S_EX:
            begin
                priority if (status.ir_op == OP_LD)
                begin
                    state_next = S_LD0;
                end
                else if (status.ir_op == OP_ST)
                begin
                    state_next = S_STZ;
                end
                else if (status.ir_op == OP_DIV)
                begin
                    state_next = S_DIV;
                end
                else if (status.ir_op == OP_READ || status.ir_op == OP_WRITE)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_STZ: state_next = S_ST0;
            S_ST0: state_next = S_ST1;
            S_ST1: state_next = S_RESP;
            S_LD0: state_next = S_LD1;
            S_LD1: state_next = S_LD2;
            S_LD2: state_next = S_RESP;
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:  state_next = S_RESP;
            S_RESP:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd_out      = '0;
        item_stall   = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall     = 1'b0;
                cmd_out.lat_in = item_valid;
            end
            S_START:
            begin
                cmd_out.clr_out = 1'b1;
                if (status.cmd == CMD_LOAD)
                begin
                    cmd_out.mem_op = MO_WR_LOAD;
                end
                else if (!status.halted)
                begin
                    cmd_out.mem_op = MO_RD_PC;
                    cmd_out.pc_inc = 1'b1;
                end
            end
            S_F1:
            begin
                cmd_out.lat_ir   = 1'b1;
                cmd_out.rf_raddr = RA_XMEM;
                priority if (status.fetch_op == OP_HALT || status.fetch_op == OP_OUT)
                begin
                    cmd_out.rf_rd = 1'b1;
                end
                else if (status.fetch_op == OP_LDC)
                begin
                    cmd_out.mem_op = MO_RD_PC;
                    cmd_out.pc_inc = 1'b1;
                end
                else if (status.fetch_op == OP_IN)
                begin
                    cmd_out.rf_wr    = 1'b1;
                    cmd_out.rf_widx  = WI_XMEM;
                    cmd_out.rf_wdata = WD_IN;
                end
                else
                begin
                    cmd_out.mem_op = MO_RD_PC;
                    cmd_out.pc_inc = 1'b1;
                    cmd_out.rf_rd  = 1'b1;
                end
            end
            S_RX:
            begin
                if (status.ir_op == OP_HALT)
                begin
                    cmd_out.set_halt = 1'b1;
                end
                else
                begin
                    cmd_out.set_out = 1'b1;
                end
            end
            S_LDC:
            begin
                cmd_out.rf_wr    = 1'b1;
                cmd_out.rf_widx  = WI_X;
                cmd_out.rf_wdata = WD_LDC;
            end
            S_F2:
            begin
                cmd_out.lat_a    = 1'b1;
                cmd_out.lat_j    = 1'b1;
                cmd_out.rf_rd    = 1'b1;
                cmd_out.rf_raddr = RA_YMEM;
            end
            S_RY:
            begin
                cmd_out.lat_b = 1'b1;
            end
            S_EX:
            begin
                priority if (status.ir_op == OP_LD)
                begin
                    cmd_out.mem_op = MO_RD_B;
                end
                else if (status.ir_op == OP_ST)
                begin
                    cmd_out.rf_rd    = 1'b1;
                    cmd_out.rf_raddr = RA_Z;
                end
                else if (status.ir_op == OP_DIV)
                begin
                    cmd_out.div_go = 1'b1;
                end
                else if (status.ir_op == OP_READ || status.ir_op == OP_WRITE)
                begin
                    cmd_out.alu_go = 1'b0;
                end
                else
                begin
                    cmd_out.alu_go = 1'b1;
                end
            end
            S_STZ:
            begin
                cmd_out.lat_c = 1'b1;
            end
            S_ST0:
            begin
                cmd_out.mem_op = MO_WR_LO;
            end
            S_ST1:
            begin
                cmd_out.mem_op   = MO_WR_HI;
                cmd_out.rf_wr    = 1'b1;
                cmd_out.rf_widx  = WI_Y;
                cmd_out.rf_wdata = WD_STY;
            end
            S_LD0:
            begin
                cmd_out.lat_lo = 1'b1;
                cmd_out.mem_op = MO_RD_B1;
            end
            S_LD1:
            begin
                cmd_out.lat_word = 1'b1;
                cmd_out.rf_wr    = 1'b1;
                cmd_out.rf_widx  = WI_Z;
                cmd_out.rf_wdata = WD_LD;
            end
            S_LD2:
            begin
                cmd_out.rf_wr    = 1'b1;
                cmd_out.rf_widx  = WI_Y;
                cmd_out.rf_wdata = WD_LDY;
            end
            S_DIV:
            begin
                cmd_out.lat_div = status.div_done;
            end
            S_WB:
            begin
                cmd_out.rf_widx  = WI_Z;
                cmd_out.rf_wdata = WD_RES;
                cmd_out.rf_wr    = (status.ir_op != OP_CP) || status.a_zero;
            end
            S_RESP:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/core/register_machine_execute.sv
// ----------------------------------------------------------------------------
// register_machine_execute
// Small 16-bit CPU: sixteen registers with the program counter in register
// zero, a byte memory, load items that write memory and step items that run
// one instruction each.
// ----------------------------------------------------------------------------
// Each item is paced by the single memory and register file ports and by the
// divider giving one bit a cycle. One item is handled at a time; the next is
// accepted in the cycle after the result is taken. Reset clears registers, halt
// flag and exit code; memory contents are undefined until written.
module register_machine_execute
    import rme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        cmd,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        halted,
    output logic [15:0] exit_value,
    output logic [15:0] program_counter
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    rme_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (dp_status),
        .cmd_out      (ctrl_cmd)
    );

    rme_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_in          (ctrl_cmd),
        .cmd             (cmd),
        .address         (address),
        .data            (data),
        .status          (dp_status),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .halted          (halted),
        .exit_value      (exit_value),
        .program_counter (program_counter)
    );

endmodule

>>> rtl/core/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_port_checks
// Port-level checks for register_machine_execute, bound to the top level.
// ----------------------------------------------------------------------------
module rme_port_checks
    import rme_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic        out_valid,
    input logic        halted,
    input logic [15:0] exit_value,
    input logic [15:0] program_counter
);

    // Only one item is in flight, so no item is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item accepted while a result is pending");

    // Once halted, the machine stays halted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halted))
        else $error("halted flag cleared");

    // The exit value changes only together with the halt.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(exit_value) |-> halted)
        else $error("exit value changed without a halt");

    // An OUT result is never reported from a halted machine.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_valid) |-> !halted)
        else $error("output byte reported while halted");

    // A stalled result stays valid and holds its program counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(program_counter)))
        else $error("stalled result changed");

endmodule

bind register_machine_execute rme_port_checks u_rme_port_checks (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .out_valid       (out_valid),
    .halted          (halted),
    .exit_value      (exit_value),
    .program_counter (program_counter)
);
